>>> sv/ihmt_pkg.sv
`default_nettype none
package ihmt_pkg;
  localparam logic [1:0] REQ_JOIN  = 2'd0;
  localparam logic [1:0] REQ_LEAVE = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [1:0] KIND_JOIN_OK   = 2'd0;
  localparam logic [1:0] KIND_JOIN_FULL = 2'd1;
  localparam logic [1:0] KIND_REPORT    = 2'd2;
  localparam logic [1:0] KIND_LEAVE     = 2'd3;

  localparam logic [31:0] ALL_ROUTERS = 32'he0000002;
  localparam logic [15:0] LFSR_TAPS   = 16'hb400;

  localparam logic CFG_UNSOL = 1'b0;
  localparam logic CFG_SEED  = 1'b1;

  // Datapath operations issued by the controller for the current slot.
  typedef enum logic [2:0] {
    OP_NONE, OP_SEARCH, OP_LEAVE, OP_JOIN_ARM, OP_QUERY, OP_TICK
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;    // first slot of a sweep: clear search results
    logic alloc;    // write the new entry at the free slot
    logic load;     // a request is accepted: capture its fields
    logic lfsr_step;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic has_free;
    logic div_busy;
    logic hit;      // tick expiry at the current slot
  } stat_t;
endpackage
`default_nettype wire

>>> sv/ihmt_datapath.sv
`default_nettype none
module ihmt_datapath #(
  parameter int SLOTS = 16,
  parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ihmt_pkg::cmd_t     cmd,
  input  wire logic [IW-1:0]      slot,
  input  wire logic [31:0]        grp,
  input  wire logic               general,
  input  wire logic [7:0]         maxr,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [15:0]        cfg_val,
  output ihmt_pkg::stat_t         stat,
  output logic [31:0]             hit_group
);
  logic [SLOTS-1:0] valid_r, armed_r, unsol_r;
  logic [15:0] timer_r [SLOTS];
  logic [31:0] group_r [SLOTS];
  logic [15:0] unsol_ticks_r, lfsr_r, lfsr_nxt;
  logic        found_r, free_ok_r;
  logic [IW-1:0] found_slot_r, free_slot_r;
  logic [15:0] interval;
  // Fields of the request being worked on.
  logic [31:0] grp_r;
  logic        general_r;
  logic [7:0]  maxr_r;
  // Restoring divider for the delay remainder, one bit per cycle.
  logic [15:0] rem_r, quo_r;
  logic [4:0]  div_cnt_r;
  logic [15:0] delay;
  logic [16:0] trial;
  logic        match;

  assign interval = (unsol_ticks_r == 16'd0) ? 16'd1 : unsol_ticks_r;
  assign match = valid_r[slot] && group_r[slot] == grp_r;
  assign trial = {rem_r, quo_r[15]} - {9'd0, (maxr_r == 8'd0) ? 8'd1 : maxr_r};
  assign delay = rem_r + 16'd1;

  always_comb begin
    lfsr_nxt = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? ihmt_pkg::LFSR_TAPS : 16'd0);
    if (lfsr_nxt == 16'd0) lfsr_nxt = 16'd1;
  end

  assign stat.found    = found_r;
  assign stat.has_free = free_ok_r;
  assign stat.div_busy = div_cnt_r != 5'd0;
  assign stat.hit      = valid_r[slot] && armed_r[slot] && timer_r[slot] <= 16'd1;
  assign hit_group     = group_r[slot];

  // Request capture and group store, no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grp_r <= grp; general_r <= general; maxr_r <= maxr;
    end
    if (cmd.alloc) group_r[free_slot_r] <= grp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; armed_r <= '0; unsol_r <= '0;
      for (int i = 0; i < SLOTS; i++) timer_r[i] <= 16'd0;
      unsol_ticks_r <= 16'd100; lfsr_r <= 16'd44257;
      found_r <= 1'b0; free_ok_r <= 1'b0; div_cnt_r <= 5'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == ihmt_pkg::CFG_UNSOL) unsol_ticks_r <= cfg_val;
        else lfsr_r <= (cfg_val == 16'd0) ? 16'd1 : cfg_val;
      end
      if (cmd.lfsr_step) lfsr_r <= lfsr_nxt;
      // The delay is drawn from the stepped generator value.
      if (cmd.div_start) begin
        rem_r <= 16'd0; quo_r <= lfsr_nxt; div_cnt_r <= 5'd16;
      end else if (div_cnt_r != 5'd0) begin
        div_cnt_r <= div_cnt_r - 5'd1;
        quo_r <= {quo_r[14:0], 1'b0};
        rem_r <= trial[16] ? {rem_r[14:0], quo_r[15]} : trial[15:0];
      end
      if (cmd.alloc) begin
        valid_r[free_slot_r] <= 1'b1; armed_r[free_slot_r] <= 1'b0;
        unsol_r[free_slot_r] <= 1'b1; timer_r[free_slot_r] <= 16'd0;
      end
      unique case (cmd.op)
        ihmt_pkg::OP_SEARCH: begin
          if (cmd.first) begin found_r <= 1'b0; free_ok_r <= 1'b0; end
          if (match && !(found_r && !cmd.first)) begin
            found_r <= 1'b1; found_slot_r <= slot;
          end
          if (!valid_r[slot] && (cmd.first || !free_ok_r)) begin
            free_ok_r <= 1'b1; free_slot_r <= slot;
          end
        end
        ihmt_pkg::OP_LEAVE: begin
          valid_r[found_slot_r] <= 1'b0; armed_r[found_slot_r] <= 1'b0;
          unsol_r[found_slot_r] <= 1'b0; timer_r[found_slot_r] <= 16'd0;
        end
        ihmt_pkg::OP_JOIN_ARM: begin
          if (cmd.first && found_r) unsol_r[found_slot_r] <= 1'b1;
          if (valid_r[slot] && (unsol_r[slot] || (cmd.first && found_r
              && found_slot_r == slot))) begin
            timer_r[slot] <= interval; armed_r[slot] <= 1'b1;
          end
        end
        ihmt_pkg::OP_QUERY: begin
          if (valid_r[slot] && (general_r || match)) begin
            unsol_r[slot] <= 1'b0; timer_r[slot] <= delay; armed_r[slot] <= 1'b1;
          end
        end
        ihmt_pkg::OP_TICK: begin
          if (valid_r[slot] && armed_r[slot]) begin
            if (timer_r[slot] > 16'd1) timer_r[slot] <= timer_r[slot] - 16'd1;
            else if (unsol_r[slot]) timer_r[slot] <= interval;
            else begin timer_r[slot] <= 16'd0; armed_r[slot] <= 1'b0; end
          end
        end
        default: ;
      endcase
    end
  end

  a_armed_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (armed_r & ~valid_r) == '0) else $error("armed slot not valid");
  a_unsol_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (unsol_r & ~valid_r) == '0) else $error("unsolicited slot not valid");
  a_lfsr_nz: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 16'd0) else $error("lfsr reached zero");
endmodule
`default_nettype wire

>>> sv/ihmt_ctrl.sv
`default_nettype none
module ihmt_ctrl #(
  parameter int SLOTS = 16,
  parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [1:0]     req,
  input  wire logic           mcast,
  input  wire logic [31:0]    grp,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [1:0]          o_kind,
  output logic [31:0]         o_group,
  output logic [31:0]         o_dest,
  output logic                o_last,
  input  wire ihmt_pkg::stat_t stat,
  input  wire logic [31:0]    hit_group,
  output ihmt_pkg::cmd_t      cmd,
  output logic [IW-1:0]       slot
);
  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_JOIN, S_DIV, S_QUERY, S_TICK, S_FLUSH
  } state_t;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  state_t state_r;
  logic [IW-1:0] slot_r;
  logic [1:0] req_r;
  logic [31:0] grp_r;
  // Held report awaiting a later one to learn whether it is the last.
  logic        pend_r;
  logic [31:0] pend_grp_r;
  logic        ob_full;

  assign slot = slot_r;
  assign ob_full = out_tvalid && !out_tready;
  assign in_tready = state_r == S_IDLE && !out_tvalid;

  always_comb begin
    cmd = '0;
    cmd.first = slot_r == '0;
    unique case (state_r)
      S_SEARCH: cmd.op = ihmt_pkg::OP_SEARCH;
      S_JOIN:   cmd.op = ihmt_pkg::OP_JOIN_ARM;
      S_QUERY:  cmd.op = ihmt_pkg::OP_QUERY;
      S_TICK:   cmd.op = ob_full ? ihmt_pkg::OP_NONE : ihmt_pkg::OP_TICK;
      S_DECIDE: begin
        if (req_r == ihmt_pkg::REQ_LEAVE && stat.found) cmd.op = ihmt_pkg::OP_LEAVE;
        cmd.alloc = req_r == ihmt_pkg::REQ_JOIN && !stat.found && stat.has_free;
      end
      default: cmd.op = ihmt_pkg::OP_NONE;
    endcase
    cmd.load = in_tvalid && in_tready;
    cmd.lfsr_step = cmd.load && req == ihmt_pkg::REQ_QUERY && mcast;
    cmd.div_start = cmd.lfsr_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; slot_r <= '0; out_tvalid <= 1'b0; pend_r <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          req_r <= req; grp_r <= grp; slot_r <= '0;
          if (req == ihmt_pkg::REQ_TICK) state_r <= S_TICK;
          else if (req == ihmt_pkg::REQ_QUERY) state_r <= mcast ? S_DIV : S_IDLE;
          else state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          slot_r <= slot_r + IW'(1);
          if (slot_r == LAST_SLOT) begin slot_r <= '0; state_r <= S_DECIDE; end
        end
        S_DECIDE: begin
          o_group <= grp_r; o_last <= 1'b1;
          if (req_r == ihmt_pkg::REQ_LEAVE) begin
            state_r <= S_IDLE;
            if (stat.found) begin
              out_tvalid <= 1'b1; o_kind <= ihmt_pkg::KIND_LEAVE;
              o_dest <= ihmt_pkg::ALL_ROUTERS;
            end
          end else if (!stat.found && !stat.has_free) begin
            out_tvalid <= 1'b1; o_kind <= ihmt_pkg::KIND_JOIN_FULL;
            o_dest <= 32'd0; state_r <= S_IDLE;
          end else state_r <= S_JOIN;
        end
        S_JOIN: begin
          slot_r <= slot_r + IW'(1);
          if (slot_r == LAST_SLOT) begin
            slot_r <= '0; state_r <= S_IDLE; out_tvalid <= 1'b1;
            o_kind <= ihmt_pkg::KIND_JOIN_OK; o_dest <= 32'd0;
          end
        end
        S_DIV: if (!stat.div_busy) state_r <= S_QUERY;
        S_QUERY: begin
          slot_r <= slot_r + IW'(1);
          if (slot_r == LAST_SLOT) begin slot_r <= '0; state_r <= S_IDLE; end
        end
        S_TICK: if (!ob_full) begin
          if (stat.hit) begin
            pend_r <= 1'b1; pend_grp_r <= hit_group;
            if (pend_r) begin
              out_tvalid <= 1'b1; o_kind <= ihmt_pkg::KIND_REPORT;
              o_group <= pend_grp_r; o_dest <= pend_grp_r; o_last <= 1'b0;
            end
          end
          slot_r <= slot_r + IW'(1);
          if (slot_r == LAST_SLOT) begin slot_r <= '0; state_r <= S_FLUSH; end
        end
        S_FLUSH: if (!ob_full) begin
          state_r <= S_IDLE; pend_r <= 1'b0;
          if (pend_r) begin
            out_tvalid <= 1'b1; o_kind <= ihmt_pkg::KIND_REPORT;
            o_group <= pend_grp_r; o_dest <= pend_grp_r; o_last <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("accept while busy");
  a_slot_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> slot_r == '0) else $error("slot counter not parked");
  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_TICK || state_r == S_FLUSH))
    else $error("pending report outside tick");
endmodule
`default_nettype wire

>>> sv/igmp_host_membership_table.sv
`default_nettype none
// IGMPv2 host membership table for GROUP_SLOTS groups. Join, leave, tick and
// link-multicast query requests sweep the table one slot per clock through a
// single shared slot datapath; other queries do not sweep it. A join first
// searches the table and then sweeps it again to arm timers, a leave or a
// full-table join only searches it, and a link-multicast query first waits
// on the bit-serial remainder of its random delay. Each tick report is held
// until the next expiry or the end of the sweep shows whether it is the last,
// and the sweep holds while the output is stalled. Configuration must be
// written only while no request is in flight.
module igmp_host_membership_table #(
  parameter int GROUP_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // group_addr[31:0], query_general[32], max_resp_ticks[40:33],
  // frame_multicast[41], zero fill
  input  wire logic [47:0] in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_group[31:0], dest_addr[63:32]
  output logic [63:0]      out_tdata,
  // out_kind[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);
  localparam int IW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  ihmt_pkg::cmd_t  cmd;
  ihmt_pkg::stat_t stat;
  logic [IW-1:0] slot;
  logic [31:0] hit_group, o_group, o_dest;

  assign out_tdata = {o_dest, o_group};

  ihmt_ctrl #(.SLOTS(GROUP_SLOTS), .IW(IW)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .req(in_tuser),
    .mcast(in_tdata[41]), .grp(in_tdata[31:0]), .out_tvalid, .out_tready,
    .o_kind(out_tuser), .o_group, .o_dest, .o_last(out_tlast),
    .stat, .hit_group, .cmd, .slot
  );

  ihmt_datapath #(.SLOTS(GROUP_SLOTS), .IW(IW)) u_dp (
    .clk, .rst_n, .cmd, .slot, .grp(in_tdata[31:0]), .general(in_tdata[32]),
    .maxr(in_tdata[40:33]), .cfg_we, .cfg_idx(cfg_idx[0]), .cfg_val(cfg_wdata),
    .stat, .hit_group
  );
endmodule
`default_nettype wire
